@@ rtl/ufc_pkg.sv @@
// Package for the UBX frame checker: shared types, register indexes, reset values
// and the status and kind codes of a frame report. No dependencies.
package ufc_pkg;

	// Configuration register indexes on the write port
	localparam logic [2:0] REG_SYNC_FIRST   = 3'd0;
	localparam logic [2:0] REG_SYNC_SECOND  = 3'd1;
	localparam logic [2:0] REG_MAX_PAYLOAD  = 3'd2;
	localparam logic [2:0] REG_NAV_CLASS    = 3'd3;
	localparam logic [2:0] REG_SOLUTION_ID  = 3'd4;
	localparam logic [2:0] REG_SOLUTION_LEN = 3'd5;
	localparam logic [2:0] REG_POSITION_ID  = 3'd6;
	localparam logic [2:0] REG_POSITION_LEN = 3'd7;

	// Register values after reset
	localparam logic [7:0]  RST_SYNC_FIRST   = 8'd181;
	localparam logic [7:0]  RST_SYNC_SECOND  = 8'd98;
	localparam logic [15:0] RST_MAX_PAYLOAD  = 16'd100;
	localparam logic [7:0]  RST_NAV_CLASS    = 8'd1;
	localparam logic [7:0]  RST_SOLUTION_ID  = 8'd6;
	localparam logic [15:0] RST_SOLUTION_LEN = 16'd52;
	localparam logic [7:0]  RST_POSITION_ID  = 8'd2;
	localparam logic [15:0] RST_POSITION_LEN = 16'd28;

	// Frame status codes
	localparam logic [1:0] STATUS_GOOD     = 2'd0;
	localparam logic [1:0] STATUS_BAD_SUM  = 2'd1;
	localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

	// Frame kind codes
	localparam logic [1:0] KIND_OTHER     = 2'd0;
	localparam logic [1:0] KIND_SOLUTION  = 2'd1;
	localparam logic [1:0] KIND_POSITION  = 2'd2;
	localparam logic [1:0] KIND_WRONG_LEN = 2'd3;

	// Configuration register contents
	typedef struct packed {
		logic [7:0]  sync_first;
		logic [7:0]  sync_second;
		logic [15:0] max_payload_len;
		logic [7:0]  nav_class_code;
		logic [7:0]  solution_id_code;
		logic [15:0] solution_length;
		logic [7:0]  position_id_code;
		logic [15:0] position_length;
	} ufc_cfg_t;

	// Parser state seen by the report logic
	typedef struct packed {
		logic        last;
		logic [7:0]  class_b;
		logic [7:0]  ident;
		logic [15:0] length;
		logic [7:0]  sum_first;
		logic [7:0]  sum_second;
		logic [7:0]  check_first;
	} ufc_frame_t;

	// One frame report
	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  class_b;
		logic [7:0]  ident;
		logic [15:0] length;
		logic [1:0]  kind;
	} ufc_report_t;

endpackage

@@ rtl/ufc_cfg_regs.sv @@
// Configuration registers of the UBX frame checker, written through a plain write port.
// Depends on ufc_pkg.
module ufc_cfg_regs
	import ufc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output ufc_cfg_t    cfg
);

	ufc_cfg_t cfg_q;

	// Each write lands in the register that its index names.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first       <= RST_SYNC_FIRST;
			cfg_q.sync_second      <= RST_SYNC_SECOND;
			cfg_q.max_payload_len  <= RST_MAX_PAYLOAD;
			cfg_q.nav_class_code   <= RST_NAV_CLASS;
			cfg_q.solution_id_code <= RST_SOLUTION_ID;
			cfg_q.solution_length  <= RST_SOLUTION_LEN;
			cfg_q.position_id_code <= RST_POSITION_ID;
			cfg_q.position_length  <= RST_POSITION_LEN;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SYNC_FIRST:   cfg_q.sync_first       <= cfg_data[7:0];
				REG_SYNC_SECOND:  cfg_q.sync_second      <= cfg_data[7:0];
				REG_MAX_PAYLOAD:  cfg_q.max_payload_len  <= cfg_data;
				REG_NAV_CLASS:    cfg_q.nav_class_code   <= cfg_data[7:0];
				REG_SOLUTION_ID:  cfg_q.solution_id_code <= cfg_data[7:0];
				REG_SOLUTION_LEN: cfg_q.solution_length  <= cfg_data;
				REG_POSITION_ID:  cfg_q.position_id_code <= cfg_data[7:0];
				REG_POSITION_LEN: cfg_q.position_length  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/ufc_parser.sv @@
// Byte-level frame parser: sync hunt, header capture, payload skip and Fletcher checksum.
// Depends on ufc_pkg.
module ufc_parser
	import ufc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	input  ufc_cfg_t   cfg,
	output ufc_frame_t frame
);

	localparam logic [3:0] PH_SYNC1   = 4'd0;
	localparam logic [3:0] PH_SYNC2   = 4'd1;
	localparam logic [3:0] PH_CLASS   = 4'd2;
	localparam logic [3:0] PH_IDENT   = 4'd3;
	localparam logic [3:0] PH_LENLO   = 4'd4;
	localparam logic [3:0] PH_LENHI   = 4'd5;
	localparam logic [3:0] PH_PAYLOAD = 4'd6;
	localparam logic [3:0] PH_CKA     = 4'd7;
	localparam logic [3:0] PH_CKB     = 4'd8;

	logic [3:0]  phase_q;
	logic [7:0]  class_q;
	logic [7:0]  ident_q;
	logic [15:0] length_q;
	logic [15:0] count_q;
	logic [7:0]  sum_a_q;
	logic [7:0]  sum_b_q;
	logic [7:0]  check_a_q;

	logic [7:0]  sum_a_nxt;
	logic [7:0]  sum_b_nxt;
	logic [15:0] length_full;
	logic [15:0] count_nxt;

	// Running Fletcher sums as they stand after adding this byte.
	always_comb begin
		sum_a_nxt   = sum_a_q + rx_byte;
		sum_b_nxt   = sum_b_q + sum_a_nxt;
		length_full = {rx_byte, length_q[7:0]};
		count_nxt   = count_q + 16'd1;
	end

	// Phase sequence; state changes only when an item is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SYNC1;
			class_q   <= '0;
			ident_q   <= '0;
			length_q  <= '0;
			count_q   <= '0;
			sum_a_q   <= '0;
			sum_b_q   <= '0;
			check_a_q <= '0;
		end else if (step) begin
			case (phase_q)
				PH_SYNC2: begin
					phase_q <= (rx_byte == cfg.sync_second) ? PH_CLASS : PH_SYNC1;
					sum_a_q <= '0;
					sum_b_q <= '0;
				end
				PH_CLASS: begin
					class_q <= rx_byte;
					sum_a_q <= sum_a_nxt;
					sum_b_q <= sum_b_nxt;
					phase_q <= PH_IDENT;
				end
				PH_IDENT: begin
					ident_q <= rx_byte;
					sum_a_q <= sum_a_nxt;
					sum_b_q <= sum_b_nxt;
					phase_q <= PH_LENLO;
				end
				PH_LENLO: begin
					length_q <= {8'd0, rx_byte};
					sum_a_q  <= sum_a_nxt;
					sum_b_q  <= sum_b_nxt;
					phase_q  <= PH_LENHI;
				end
				PH_LENHI: begin
					length_q <= length_full;
					sum_a_q  <= sum_a_nxt;
					sum_b_q  <= sum_b_nxt;
					count_q  <= '0;
					phase_q  <= (length_full == 16'd0) ? PH_CKA : PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					sum_a_q <= sum_a_nxt;
					sum_b_q <= sum_b_nxt;
					count_q <= count_nxt;
					if (count_nxt >= length_q) begin
						phase_q <= PH_CKA;
					end
				end
				PH_CKA: begin
					check_a_q <= rx_byte;
					phase_q   <= PH_CKB;
				end
				PH_CKB: begin
					phase_q <= PH_SYNC1;
				end
				default: begin
					phase_q <= (rx_byte == cfg.sync_first) ? PH_SYNC2 : PH_SYNC1;
				end
			endcase
		end
	end

	// The byte now waiting closes a frame when the parser sits on the second checksum byte.
	always_comb begin
		frame.last        = (phase_q == PH_CKB);
		frame.class_b     = class_q;
		frame.ident       = ident_q;
		frame.length      = length_q;
		frame.sum_first   = sum_a_q;
		frame.sum_second  = sum_b_q;
		frame.check_first = check_a_q;
	end

endmodule

@@ rtl/ufc_report.sv @@
// Frame report logic: status from length limit and checksum, kind from class, id and length.
// Depends on ufc_pkg.
module ufc_report
	import ufc_pkg::*;
(
	input  ufc_frame_t  frame,
	input  logic [7:0]  rx_byte,
	input  ufc_cfg_t    cfg,
	output ufc_report_t report
);

	logic is_nav;
	logic is_solution;
	logic is_position;

	// Known-message matching; the solution test takes priority on equal ids.
	always_comb begin
		is_nav      = (frame.class_b == cfg.nav_class_code);
		is_solution = is_nav && (frame.ident == cfg.solution_id_code);
		is_position = is_nav && (frame.ident == cfg.position_id_code);
	end

	// A too-long frame reports that status whatever its checksum; only good frames get a kind.
	always_comb begin
		report.class_b = frame.class_b;
		report.ident   = frame.ident;
		report.length  = frame.length;
		report.kind    = KIND_OTHER;
		if (frame.length > cfg.max_payload_len) begin
			report.status = STATUS_TOO_LONG;
		end else if (frame.check_first != frame.sum_first || rx_byte != frame.sum_second) begin
			report.status = STATUS_BAD_SUM;
		end else begin
			report.status = STATUS_GOOD;
			if (is_solution) begin
				report.kind = (frame.length == cfg.solution_length) ? KIND_SOLUTION
					: KIND_WRONG_LEN;
			end else if (is_position) begin
				report.kind = (frame.length == cfg.position_length) ? KIND_POSITION
					: KIND_WRONG_LEN;
			end
		end
	end

endmodule

@@ rtl/ubx_frame_checker.sv @@
// Top level of the UBX frame checker: input byte register, parser, report logic and
// result register. Depends on ufc_pkg, ufc_cfg_regs, ufc_parser and ufc_report.
//
// Usage: received bytes enter on the input channel (in_valid, in_stall, rx_byte), one item
// per byte. The block hunts for the two sync bytes, reads class, id and length, skips the
// payload and checks the two Fletcher checksum bytes. After the second checksum byte one
// frame report leaves on the output channel (out_valid, out_stall, frame_* fields); all
// other bytes give no report.
// The report is registered: the last byte of a frame waits in the input byte register,
// then its report loads into the result register once that register is free.
// Throughput: one byte per cycle while the result register can take a frame-closing byte.
// The user must write the configuration through cfg_we, cfg_index and cfg_data only while
// the block is idle; the block itself does not enforce this. Reset clears the parser to
// hunting the first sync byte, empties both registers and loads the default configuration.
// When the receiver stalls, the waiting report holds; bytes that do not close a frame keep
// flowing, and a byte that closes a frame waits in the input register, stalling the input
// channel, until the result register frees up.
module ubx_frame_checker
	import ufc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  frame_status,
	output logic [7:0]  frame_class,
	output logic [7:0]  frame_ident,
	output logic [15:0] frame_length,
	output logic [1:0]  frame_kind
);

	ufc_cfg_t    cfg;
	ufc_frame_t  frame;
	ufc_report_t report;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        res_valid_s2;
	ufc_report_t res_s2;

	logic out_free;
	logic advance;
	logic in_accept;

	ufc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ufc_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.frame   (frame)
	);

	ufc_report u_report (
		.frame   (frame),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.report  (report)
	);

	// Flow control: only a frame-closing byte needs room in the result register.
	always_comb begin
		out_free  = !res_valid_s2 || !out_stall;
		advance   = valid_s1 && (!frame.last || out_free);
		in_stall  = valid_s1 && !advance;
		in_accept = in_valid && !in_stall;
	end

	// Input byte register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= rx_byte;
		end
	end

	// Result register: loads a report when a frame closes, empties when the report is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance && frame.last) begin
			res_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && frame.last) begin
			res_s2 <= report;
		end
	end

	assign out_valid    = res_valid_s2;
	assign frame_status = res_s2.status;
	assign frame_class  = res_s2.class_b;
	assign frame_ident  = res_s2.ident;
	assign frame_length = res_s2.length;
	assign frame_kind   = res_s2.kind;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for ubx_frame_checker: random byte streams of framed and broken
// traffic are checked against a byte-level model of the parser kept in a scoreboard class.
// Depends on ufc_pkg and the ubx_frame_checker RTL.
module testbench;
	import ufc_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int LONG_HOLD    = 300;
	localparam int RANDOM_BYTES = 1650;
	localparam int BYTES_PER_SETTING = 220;

	typedef enum logic [3:0] {
		HUNT_SYNC1, HUNT_SYNC2, GET_CLASS, GET_IDENT, GET_LEN_LO, GET_LEN_HI,
		IN_PAYLOAD, GET_CK_A, GET_CK_B
	} parse_phase_e;

	typedef enum int {DMG_NONE, DMG_FIRST, DMG_SECOND, DMG_BOTH} check_damage_e;

	// Scoreboard: tracks the frame parser byte by byte and queues the reports it predicts.
	class frame_report_board;
		ufc_cfg_t     cfg;
		parse_phase_e phase;
		logic [7:0]   cls, ident, sum_a, sum_b, check_a;
		logic [15:0]  len, count;
		ufc_report_t  awaited[$];
		int           mismatches;
		int           checked;
		int           by_status[4];

		function new();
			cfg.sync_first       = RST_SYNC_FIRST;
			cfg.sync_second      = RST_SYNC_SECOND;
			cfg.max_payload_len  = RST_MAX_PAYLOAD;
			cfg.nav_class_code   = RST_NAV_CLASS;
			cfg.solution_id_code = RST_SOLUTION_ID;
			cfg.solution_length  = RST_SOLUTION_LEN;
			cfg.position_id_code = RST_POSITION_ID;
			cfg.position_length  = RST_POSITION_LEN;
			phase = HUNT_SYNC1;
			cls = '0;
			ident = '0;
			sum_a = '0;
			sum_b = '0;
			check_a = '0;
			len = '0;
			count = '0;
			mismatches = 0;
			checked = 0;
			foreach (by_status[i]) by_status[i] = 0;
		endfunction

		// Mirror of a register write; narrow registers keep only their low byte.
		function void write_reg(logic [2:0] idx, logic [15:0] val);
			case (idx)
				REG_SYNC_FIRST:   cfg.sync_first = val[7:0];
				REG_SYNC_SECOND:  cfg.sync_second = val[7:0];
				REG_MAX_PAYLOAD:  cfg.max_payload_len = val;
				REG_NAV_CLASS:    cfg.nav_class_code = val[7:0];
				REG_SOLUTION_ID:  cfg.solution_id_code = val[7:0];
				REG_SOLUTION_LEN: cfg.solution_length = val;
				REG_POSITION_ID:  cfg.position_id_code = val[7:0];
				REG_POSITION_LEN: cfg.position_length = val;
				default: ;
			endcase
		endfunction

		function void add_sum(logic [7:0] b);
			sum_a = sum_a + b;
			sum_b = sum_b + sum_a;
		endfunction

		// The solution test is made first, so it wins when both ids are equal.
		function logic [1:0] expected_kind();
			if (cls == cfg.nav_class_code && ident == cfg.solution_id_code)
				return (len == cfg.solution_length) ? KIND_SOLUTION : KIND_WRONG_LEN;
			if (cls == cfg.nav_class_code && ident == cfg.position_id_code)
				return (len == cfg.position_length) ? KIND_POSITION : KIND_WRONG_LEN;
			return KIND_OTHER;
		endfunction

		// Advances the parser by one accepted byte; a closing byte queues one report.
		function void note_byte(logic [7:0] b);
			ufc_report_t r;
			case (phase)
				HUNT_SYNC2: begin
					phase = (b == cfg.sync_second) ? GET_CLASS : HUNT_SYNC1;
					sum_a = '0;
					sum_b = '0;
				end
				GET_CLASS: begin
					cls = b;
					add_sum(b);
					phase = GET_IDENT;
				end
				GET_IDENT: begin
					ident = b;
					add_sum(b);
					phase = GET_LEN_LO;
				end
				GET_LEN_LO: begin
					len = {8'h00, b};
					add_sum(b);
					phase = GET_LEN_HI;
				end
				GET_LEN_HI: begin
					len[15:8] = b;
					add_sum(b);
					count = '0;
					phase = (len == 16'd0) ? GET_CK_A : IN_PAYLOAD;
				end
				IN_PAYLOAD: begin
					add_sum(b);
					count = count + 16'd1;
					if (count >= len)
						phase = GET_CK_A;
				end
				GET_CK_A: begin
					check_a = b;
					phase = GET_CK_B;
				end
				GET_CK_B: begin
					if (len > cfg.max_payload_len)
						r.status = STATUS_TOO_LONG;
					else if (check_a != sum_a || b != sum_b)
						r.status = STATUS_BAD_SUM;
					else
						r.status = STATUS_GOOD;
					r.class_b = cls;
					r.ident = ident;
					r.length = len;
					r.kind = (r.status == STATUS_GOOD) ? expected_kind() : KIND_OTHER;
					awaited.push_back(r);
					phase = HUNT_SYNC1;
				end
				default: begin
					phase = (b == cfg.sync_first) ? HUNT_SYNC2 : HUNT_SYNC1;
				end
			endcase
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		// Compares one report from the block with the oldest predicted one.
		task check_report(ufc_report_t got);
			ufc_report_t want;
			bit wrong;
			checked++;
			if (awaited.size() == 0) begin
				report_mismatch($sformatf(
					"report with none due: status %0d class %02h id %02h len %0d kind %0d",
					got.status, got.class_b, got.ident, got.length, got.kind));
			end else begin
				want = awaited.pop_front();
				by_status[want.status]++;
				wrong = 1'b0;
				if (got.status !== want.status) wrong = 1'b1;
				if (got.class_b !== want.class_b) wrong = 1'b1;
				if (got.ident !== want.ident) wrong = 1'b1;
				if (got.length !== want.length) wrong = 1'b1;
				if (got.kind !== want.kind) wrong = 1'b1;
				if (wrong)
					report_mismatch($sformatf({"got status %0d class %02h id %02h len %0d ",
						"kind %0d, want %0d %02h %02h %0d %0d"},
						got.status, got.class_b, got.ident, got.length, got.kind,
						want.status, want.class_b, want.ident, want.length, want.kind));
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic [7:0]  rx_byte = '0;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [1:0]  frame_status;
	logic [7:0]  frame_class;
	logic [7:0]  frame_ident;
	logic [15:0] frame_length;
	logic [1:0]  frame_kind;

	frame_report_board board;
	int bytes_sent = 0;
	int random_bytes = 0;
	int settings_used = 1;
	bit gaps_on = 1'b1;
	bit hold_request = 1'b0;
	bit hold_active = 1'b0;

	ubx_frame_checker dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.frame_status(frame_status),
		.frame_class(frame_class),
		.frame_ident(frame_ident),
		.frame_length(frame_length),
		.frame_kind(frame_kind)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Run limit: ends the run as failed if the stream never drains.
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// Report monitor: values are sampled as they stood just before the edge.
	always @(posedge clk) begin : report_monitor
		ufc_report_t seen;
		seen = {frame_status, frame_class, frame_ident, frame_length, frame_kind};
		if (arst_n && out_valid && !out_stall)
			board.check_report(seen);
	end

	// Receiver: stretches of free flow, random stalls and full stalls, plus one long hold.
	initial begin : receiver
		int stretch, mode, pct;
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_active = 1'b1;
				for (int k = 0; k < LONG_HOLD; k++) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
				hold_request = 1'b0;
				hold_active = 1'b0;
			end else begin
				mode = $urandom_range(0, 9);
				stretch = (mode < 4) ? $urandom_range(5, 60) : $urandom_range(5, 40);
				pct = (mode < 4) ? 0 : (mode < 9) ? 35 : 100;
				for (int k = 0; k < stretch; k++) begin
					out_stall <= ($urandom_range(0, 99) < pct);
					@(posedge clk);
				end
			end
		end
	end

	// Offers one byte, with an optional idle gap first, and waits until it is taken.
	task automatic send_byte(input logic [7:0] b);
		int r;
		r = $urandom_range(0, 99);
		if (gaps_on && r >= 70) begin
			in_valid <= 1'b0;
			repeat ((r >= 95) ? $urandom_range(8, 40) : $urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_byte(b);
		bytes_sent++;
	endtask

	// Sends a whole frame with random payload; the checksum may be damaged on purpose.
	task automatic send_frame(input logic [7:0] cls, input logic [7:0] ident,
			input logic [15:0] len, input check_damage_e damage);
		logic [7:0] hdr[4];
		logic [7:0] a, b, pb;
		a = '0;
		b = '0;
		hdr = '{cls, ident, len[7:0], len[15:8]};
		send_byte(board.cfg.sync_first);
		send_byte(board.cfg.sync_second);
		foreach (hdr[i]) begin
			a = a + hdr[i];
			b = b + a;
			send_byte(hdr[i]);
		end
		for (int i = 0; i < len; i++) begin
			pb = 8'($urandom);
			a = a + pb;
			b = b + a;
			send_byte(pb);
		end
		if (damage == DMG_FIRST || damage == DMG_BOTH)
			a = a ^ (8'd1 << $urandom_range(0, 7));
		if (damage == DMG_SECOND || damage == DMG_BOTH)
			b = b ^ (8'd1 << $urandom_range(0, 7));
		send_byte(a);
		send_byte(b);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		board.write_reg(idx, val);
	endtask

	// Waits until every predicted report has arrived and the pipeline has emptied.
	task automatic settle();
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		ufc_cfg_t      next_cfg;
		int            setting, phase_start, action, pick, mark;
		logic [7:0]    cls, ident, other;
		logic [15:0]   len;
		check_damage_e damage;

		board = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening under the reset configuration: extreme junk bytes, a repeated
		// first sync byte that must not be retried, and zero-length frames.
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(RST_SYNC_FIRST);
		send_byte(RST_SYNC_FIRST);
		send_byte(RST_SYNC_SECOND);
		send_frame(8'hFF, 8'h00, 16'd0, DMG_NONE);
		send_frame(RST_NAV_CLASS, RST_SOLUTION_ID, 16'd0, DMG_NONE);
		send_frame(8'h00, 8'hFF, 16'd0, DMG_BOTH);

		setting = 0;
		while (random_bytes < RANDOM_BYTES) begin
			// New register setting between phases: all low, all high, then random.
			if (setting > 0) begin
				settle();
				if (setting == 1) begin
					next_cfg = '0;
				end else if (setting == 2) begin
					next_cfg = '1;
				end else begin
					next_cfg.sync_first = 8'($urandom);
					next_cfg.sync_second = 8'($urandom);
					next_cfg.max_payload_len = 16'($urandom_range(0, 40));
					next_cfg.nav_class_code = $urandom_range(0, 1) ? RST_NAV_CLASS : 8'($urandom);
					next_cfg.solution_id_code = 8'($urandom);
					next_cfg.position_id_code = ($urandom_range(0, 3) == 0) ?
						next_cfg.solution_id_code : 8'($urandom);
					next_cfg.solution_length = 16'($urandom_range(0, 24));
					next_cfg.position_length = 16'($urandom_range(0, 24));
				end
				write_reg(REG_SYNC_FIRST, {8'($urandom), next_cfg.sync_first});
				write_reg(REG_SYNC_SECOND, {8'($urandom), next_cfg.sync_second});
				write_reg(REG_MAX_PAYLOAD, next_cfg.max_payload_len);
				write_reg(REG_NAV_CLASS, {8'($urandom), next_cfg.nav_class_code});
				write_reg(REG_SOLUTION_ID, {8'($urandom), next_cfg.solution_id_code});
				write_reg(REG_SOLUTION_LEN, next_cfg.solution_length);
				write_reg(REG_POSITION_ID, {8'($urandom), next_cfg.position_id_code});
				write_reg(REG_POSITION_LEN, next_cfg.position_length);
				cfg_we <= 1'b0;
				settings_used++;
			end

			// Back-pressure: the receiver holds off while short frames keep coming.
			if (setting == 3) begin
				hold_request = 1'b1;
				while (!hold_active) @(posedge clk);
				gaps_on = 1'b0;
				mark = bytes_sent;
				repeat (25)
					send_frame(board.cfg.nav_class_code, board.cfg.solution_id_code, 16'd0,
						DMG_NONE);
				random_bytes += bytes_sent - mark;
			end

			phase_start = random_bytes;
			while (random_bytes - phase_start < BYTES_PER_SETTING) begin
				mark = bytes_sent;
				gaps_on = ($urandom_range(0, 3) != 0);
				action = $urandom_range(0, 99);
				if (action < 8) begin
					// Noise while hunting; never a first sync byte, so nothing starts.
					repeat ($urandom_range(1, 4)) begin
						do other = 8'($urandom); while (other == board.cfg.sync_first);
						send_byte(other);
					end
					random_bytes += bytes_sent - mark;
				end else if (action < 15) begin
					// First sync byte followed by a wrong second one.
					send_byte(board.cfg.sync_first);
					if (board.cfg.sync_first != board.cfg.sync_second && $urandom_range(0, 1))
						other = board.cfg.sync_first;
					else
						do other = 8'($urandom); while (other == board.cfg.sync_second);
					send_byte(other);
					random_bytes += bytes_sent - mark;
				end else begin
					// Well-formed frame, mostly navigation messages near the set lengths.
					if ($urandom_range(0, 99) < 65) begin
						cls = board.cfg.nav_class_code;
						pick = $urandom_range(0, 9);
						if (pick < 4)
							ident = board.cfg.solution_id_code;
						else if (pick < 8)
							ident = board.cfg.position_id_code;
						else
							ident = 8'($urandom);
					end else begin
						cls = 8'($urandom);
						ident = 8'($urandom);
					end
					pick = $urandom_range(0, 99);
					if (pick < 28)
						len = board.cfg.solution_length;
					else if (pick < 50)
						len = board.cfg.position_length;
					else if (pick < 66)
						len = 16'($urandom_range(0, 12));
					else if (pick < 76)
						len = board.cfg.max_payload_len;
					else if (pick < 96)
						len = board.cfg.max_payload_len + 16'($urandom_range(1, 4));
					else if (pick == 96)
						len = 16'h0100 | 16'($urandom_range(0, 4));
					else
						len = 16'($urandom_range(0, 3));
					if (len > 16'd64 && pick != 96)
						len = 16'($urandom_range(0, 12));
					if (ident == board.cfg.solution_id_code && $urandom_range(0, 9) < 6 &&
							board.cfg.solution_length <= 16'd64)
						len = board.cfg.solution_length;
					else if (ident == board.cfg.position_id_code && $urandom_range(0, 9) < 6 &&
							board.cfg.position_length <= 16'd64)
						len = board.cfg.position_length;
					pick = $urandom_range(0, 99);
					if (pick < 75)
						damage = DMG_NONE;
					else if (pick < 83)
						damage = DMG_FIRST;
					else if (pick < 91)
						damage = DMG_SECOND;
					else
						damage = DMG_BOTH;
					send_frame(cls, ident, len, damage);
					random_bytes += bytes_sent - mark;
				end
			end
			setting++;
		end

		gaps_on = 1'b1;
		settle();
		$display("Run covered %0d bytes and %0d frame reports over %0d register settings.",
			bytes_sent, board.checked, settings_used);
		$display("Reports by status: good %0d, bad checksum %0d, too long %0d.",
			board.by_status[STATUS_GOOD], board.by_status[STATUS_BAD_SUM],
			board.by_status[STATUS_TOO_LONG]);
		if (board.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
